### hdl/hcbp_pkg.sv
// Package for the code bit packer: sizes, item and word types, command codes.
// Depends on nothing; every other file of the block but hcbp_ram imports it.
`default_nettype none

package hcbp_pkg;

	// Table size and output word size.
	localparam int NUM_SYMBOLS = 257;
	localparam int WORD_BITS   = 64;
	localparam int EOS_SYMBOL  = 256;
	localparam int BYTE_BITS   = 8;

	// Fixed widths of the external fields.
	localparam int CMD_W   = 2;
	localparam int SYM_W   = 9;
	localparam int CLEN_W  = 7;
	localparam int CBITS_W = 64;
	localparam int PWORD_W = 64;

	// Derived internal widths. IDX_W covers the largest table index.
	localparam int IDX_W   = 10;
	localparam int ADDR_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int LEN_W   = $clog2(WORD_BITS + 1);
	localparam int FILL_W  = $clog2(WORD_BITS);
	localparam int ENTRY_W = LEN_W + WORD_BITS;

	// Queue depths (powers of two, so pointers wrap on their own).
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int ODEPTH = 2;
	localparam int OPTR_W = $clog2(ODEPTH);
	localparam int OCNT_W = $clog2(ODEPTH + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [SYM_W-1:0]   symbol;
		logic [CLEN_W-1:0]  code_length;
		logic [CBITS_W-1:0] code_bits;
	} in_item_t;

	typedef struct packed {
		logic [PWORD_W-1:0] packed_word;
		logic               final_word;
		logic               end_of_run;
	} out_item_t;

	// One code table entry as stored in the RAM.
	typedef struct packed {
		logic [LEN_W-1:0]     len;
		logic [WORD_BITS-1:0] val;
	} entry_t;

	// One packing job from the front to the back.
	typedef struct packed {
		logic                 is_finish;
		logic [LEN_W-1:0]     len;
		logic [WORD_BITS-1:0] val;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_req_t;

	typedef enum logic {
		BK_APPEND = 1'b0,
		BK_FLUSH  = 1'b1
	} back_state_t;

endpackage

`default_nettype wire

### hdl/hcbp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read; the read sees the contents before a same-edge write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/hcbp_front.sv
// Front end: takes input words, writes the code table, looks up codes for jobs.
// Depends on hcbp_pkg and hcbp_ram.
`default_nettype none

module hcbp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire hcbp_pkg::in_item_t item,
	input  wire logic              q_ready,
	output hcbp_pkg::job_req_t     q_push
);

	import hcbp_pkg::*;

	logic                 accept;
	logic                 is_load;
	logic                 is_job;
	logic [IDX_W-1:0]     idx;
	logic                 in_range;
	logic [ADDR_W-1:0]    addr;
	logic [LEN_W-1:0]     ld_len;
	logic [WORD_BITS-1:0] ld_val;
	logic                 we;
	logic                 re;
	entry_t               wr_entry;
	logic [ENTRY_W-1:0]   rd_raw;
	entry_t               rd_entry;
	logic [NUM_SYMBOLS-1:0] vld_q;
	logic                 job_valid_s1;
	logic                 is_finish_s1;
	logic                 hit_s1;

	// The lookup stage holds one job; it blocks new words only when it cannot move on.
	assign full   = job_valid_s1 && !q_ready;
	assign accept = push && !full;

	// Classify the word and form the table index.
	always_comb begin
		is_load = (item.cmd == CMD_LOAD);
		is_job  = (item.cmd == CMD_ENCODE) || (item.cmd == CMD_FINISH);
		if (item.cmd == CMD_FINISH) begin
			idx = IDX_W'(EOS_SYMBOL);
		end else if (item.cmd == CMD_LOAD) begin
			idx = IDX_W'(item.symbol);
		end else begin
			idx = IDX_W'(item.symbol[BYTE_BITS-1:0]);
		end
		in_range = ({1'b0, idx} < (IDX_W + 1)'(NUM_SYMBOLS));
		addr     = idx[ADDR_W-1:0];
	end

	// A loaded length saturates at the word size; code bits above it are dropped.
	always_comb begin
		if (item.code_length > CLEN_W'(WORD_BITS)) begin
			ld_len = LEN_W'(WORD_BITS);
		end else begin
			ld_len = item.code_length[LEN_W-1:0];
		end
		ld_val       = item.code_bits[WORD_BITS-1:0] & ~({WORD_BITS{1'b1}} << ld_len);
		wr_entry.len = ld_len;
		wr_entry.val = ld_val;
	end

	assign we = accept && is_load && in_range;
	assign re = accept && is_job;

	hcbp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_SYMBOLS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (addr),
		.wdata (wr_entry),
		.re    (re),
		.raddr (addr),
		.rdata (rd_raw)
	);

	assign rd_entry = entry_t'(rd_raw);

	// Per-entry valid bits: an entry never loaded since reset reads as length zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[addr] <= 1'b1;
		end
	end

	// Lookup stage control, aligned with the RAM read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (re) begin
			job_valid_s1 <= 1'b1;
		end else if (q_ready) begin
			job_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			is_finish_s1 <= (item.cmd == CMD_FINISH);
			hit_s1       <= in_range && vld_q[addr];
		end
	end

	// Job handed to the queue; a missing entry becomes an empty code with no bits.
	always_comb begin
		q_push.valid         = job_valid_s1;
		q_push.job.is_finish = is_finish_s1;
		q_push.job.len       = hit_s1 ? rd_entry.len : '0;
		q_push.job.val       = hit_s1 ? rd_entry.val : '0;
	end

endmodule

`default_nettype wire

### hdl/hcbp_job_queue.sv
// Short job queue between the lookup front end and the packer.
// Depends on hcbp_pkg.
`default_nettype none

module hcbp_job_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hcbp_pkg::job_req_t q_push,
	output logic                    q_ready,
	output hcbp_pkg::job_req_t      q_head,
	input  wire logic               q_pop
);

	import hcbp_pkg::*;

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	// Room is judged on the registered count alone.
	assign q_ready = (cnt_q < QCNT_W'(QDEPTH));
	assign do_push = q_push.valid && q_ready;
	assign do_pop  = q_pop && (cnt_q != '0);

	assign q_head.valid = (cnt_q != '0);
	assign q_head.job   = slot_q[rptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= q_push.job;
		end
	end

endmodule

`default_nettype wire

### hdl/hcbp_back.sv
// Packer: appends codes MSB first to the accumulator and queues output words.
// Depends on hcbp_pkg.
`default_nettype none

module hcbp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hcbp_pkg::job_req_t q_head,
	output logic                    q_pop,
	output logic                    empty,
	input  wire logic               pop,
	output hcbp_pkg::out_item_t     result
);

	import hcbp_pkg::*;

	back_state_t          state_q;
	back_state_t          state_d;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] acc_d;
	logic [FILL_W-1:0]    fill_q;
	logic [FILL_W-1:0]    fill_d;

	logic [LEN_W-1:0]     fill_ext;
	logic [LEN_W-1:0]     room;
	logic [LEN_W-1:0]     rest;
	logic [LEN_W-1:0]     fill_sum;
	logic                 fits;
	logic [FILL_W-1:0]    new_fill;
	logic [WORD_BITS-1:0] app_word;
	logic [WORD_BITS-1:0] app_acc;
	logic [WORD_BITS-1:0] flush_word;
	logic                 out_room;

	logic                 wr_en;
	out_item_t            wr_item;

	out_item_t            obuf_q [ODEPTH];
	logic [OPTR_W-1:0]    owptr_q;
	logic [OPTR_W-1:0]    orptr_q;
	logic [OCNT_W-1:0]    ocnt_q;
	logic                 do_opop;

	assign out_room = (ocnt_q < OCNT_W'(ODEPTH));

	// Append datapath: at most one word boundary is crossed per code.
	always_comb begin
		fill_ext   = LEN_W'(fill_q);
		room       = LEN_W'(WORD_BITS) - fill_ext;
		fits       = (q_head.job.len < room);
		rest       = q_head.job.len - room;
		fill_sum   = fill_ext + q_head.job.len;
		new_fill   = fits ? fill_sum[FILL_W-1:0] : rest[FILL_W-1:0];
		app_word   = (q_head.job.val >> rest) | (acc_q << room);
		if (fits) begin
			app_acc = (acc_q << q_head.job.len) | q_head.job.val;
		end else begin
			app_acc = q_head.job.val & ~({WORD_BITS{1'b1}} << rest);
		end
		flush_word = acc_q << room;
	end

	// Next state: a finish that leaves a partial word goes on to flush it.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_APPEND: begin
				if (q_head.valid && out_room && q_head.job.is_finish && (new_fill != '0)) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (out_room) begin
					state_d = BK_APPEND;
				end
			end
			default: begin
				state_d = BK_APPEND;
			end
		endcase
	end

	// Outputs of the packer: job pop, word write and accumulator update.
	always_comb begin
		q_pop   = 1'b0;
		wr_en   = 1'b0;
		wr_item = '0;
		acc_d   = acc_q;
		fill_d  = fill_q;
		case (state_q)
			BK_APPEND: begin
				if (q_head.valid && out_room) begin
					acc_d  = app_acc;
					fill_d = new_fill;
					wr_en  = !fits;
					wr_item.packed_word = PWORD_W'(app_word);
					if (q_head.job.is_finish) begin
						wr_item.final_word = (new_fill == '0);
						wr_item.end_of_run = (new_fill == '0);
						if (new_fill == '0) begin
							q_pop = 1'b1;
							acc_d = '0;
						end
					end else begin
						wr_item.final_word = 1'b0;
						wr_item.end_of_run = 1'b1;
						q_pop = 1'b1;
					end
				end
			end
			BK_FLUSH: begin
				if (out_room) begin
					wr_en   = 1'b1;
					wr_item.packed_word = PWORD_W'(flush_word);
					wr_item.final_word  = 1'b1;
					wr_item.end_of_run  = 1'b1;
					q_pop  = 1'b1;
					acc_d  = '0;
					fill_d = '0;
				end
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// Packer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_APPEND;
			acc_q   <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
			fill_q  <= fill_d;
		end
	end

	// Output word queue.
	assign empty   = (ocnt_q == '0);
	assign do_opop = pop && !empty;
	assign result  = obuf_q[orptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= '0;
			orptr_q <= '0;
			ocnt_q  <= '0;
		end else begin
			if (wr_en) begin
				owptr_q <= owptr_q + 1'b1;
			end
			if (do_opop) begin
				orptr_q <= orptr_q + 1'b1;
			end
			if (wr_en && !do_opop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (do_opop && !wr_en) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			obuf_q[owptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

### hdl/huffman_code_bit_packer_unit.sv
// Top level of the code bit packer: front end, job queue and packer.
// Depends on hcbp_pkg, hcbp_front, hcbp_job_queue and hcbp_back.
//
//  Channel   Handshake         Word type    Direction
//  -------   ---------------   ----------   ---------
//  input     push / full       in_item_t    in
//  result    pop / empty       out_item_t   out
//
// One input word is taken per cycle while full is low. Loads finish in the table RAM
// at acceptance; encode and finish words read the table at acceptance, wait in the
// registered lookup stage, enter the job queue and are then packed into the result
// queue. The packer retires a job in its append state; a finish that leaves a
// partial word goes on to its flush state to write that word.
// Reset clears the table valid bits at once; no clearing pass is needed.
// Full rises when the job queue is full and a looked-up job waits for it; the
// packer stalls when the result queue is full.
`default_nettype none

module huffman_code_bit_packer_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire hcbp_pkg::in_item_t item,
	output logic                    empty,
	input  wire logic               pop,
	output hcbp_pkg::out_item_t     result
);

	import hcbp_pkg::*;

	job_req_t q_push;
	job_req_t q_head;
	logic     q_ready;
	logic     q_pop;

	hcbp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_ready (q_ready),
		.q_push  (q_push)
	);

	hcbp_job_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.q_ready (q_ready),
		.q_head  (q_head),
		.q_pop   (q_pop)
	);

	hcbp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	// The packer only retires a job that is there.
	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head.valid)
		else $error("packer popped an empty job queue");

	// Back pressure comes only from a held lookup job.
	a_full_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (q_push.valid && !q_ready))
		else $error("full raised without a stalled lookup job");

	// A table load leaves no job in the lookup stage.
	a_load_no_job: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && (item.cmd == CMD_LOAD)) |=> !q_push.valid)
		else $error("table load produced a lookup job");

	// The final word of a stream always closes its input word's run.
	a_final_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.final_word) |-> result.end_of_run)
		else $error("final word without end of run");

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for huffman_code_bit_packer_unit: code table loads, byte
// encoding and stream ends, with every packed word checked against a built-in model.
// Depends on hcbp_pkg and the block's RTL only.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hcbp_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int TOTAL_ITEMS    = 1550;
	localparam int DRAIN_TAIL     = 16;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum int {
		POP_ALWAYS,
		POP_MOSTLY,
		POP_RARELY,
		POP_PATTERN
	} pop_mode_t;

	// Model of the code table and the bit packer, plus the words still owed by the block.
	class packed_word_model_t;
		logic [CLEN_W-1:0]    code_len_tab [NUM_SYMBOLS];
		logic [WORD_BITS-1:0] code_val_tab [NUM_SYMBOLS];
		logic [WORD_BITS-1:0] acc;
		logic [FILL_W-1:0]    fill;
		out_item_t            step_words[$];
		out_item_t            expected_words[$];
		int unsigned          failures, n_loads, n_encodes, n_finishes, n_words, n_final;
		int unsigned          n_items;

		function new();
			foreach (code_len_tab[i]) begin
				code_len_tab[i] = '0;
				code_val_tab[i] = '0;
			end
			acc = '0;
			fill = '0;
			failures = 0;
			n_loads = 0;
			n_encodes = 0;
			n_finishes = 0;
			n_words = 0;
			n_final = 0;
			n_items = 0;
		endfunction

		function logic [WORD_BITS-1:0] low_mask(int unsigned n);
			if (n >= WORD_BITS)
				return '1;
			return (64'd1 << n) - 64'd1;
		endfunction

		// Append one symbol's code; a word that fills up goes to step_words.
		function void append_code(int unsigned idx);
			int unsigned          len, room, rest;
			logic [WORD_BITS-1:0] val, word;
			out_item_t            w;
			if (idx >= NUM_SYMBOLS)
				return;
			len = code_len_tab[idx];
			if (len == 0)
				return;
			val = code_val_tab[idx] & low_mask(len);
			room = WORD_BITS - int'(fill);
			if (len < room) begin
				acc = (acc << len) | val;
				fill = FILL_W'(int'(fill) + len);
				return;
			end
			rest = len - room;
			word = val >> rest;
			if (room < WORD_BITS)
				word |= acc << room;
			w.packed_word = word;
			w.final_word = 1'b0;
			w.end_of_run = 1'b0;
			step_words.push_back(w);
			acc = val & low_mask(rest);
			fill = FILL_W'(rest);
		endfunction

		// Called for every accepted input word; queues the packed words it causes.
		function void note_item(in_item_t it);
			logic [CLEN_W-1:0] len;
			out_item_t         w;
			step_words.delete();
			n_items++;
			case (it.cmd)
				CMD_LOAD: begin
					if (it.symbol < NUM_SYMBOLS) begin
						len = (it.code_length > WORD_BITS) ? CLEN_W'(WORD_BITS) : it.code_length;
						code_len_tab[it.symbol] = len;
						code_val_tab[it.symbol] = it.code_bits & low_mask(len);
						n_loads++;
					end
				end
				CMD_ENCODE: begin
					append_code(it.symbol[BYTE_BITS-1:0]);
					n_encodes++;
				end
				CMD_FINISH: begin
					append_code(EOS_SYMBOL);
					if (fill != 0) begin
						w.packed_word = acc << (WORD_BITS - int'(fill));
						w.final_word = 1'b1;
						w.end_of_run = 1'b0;
						step_words.push_back(w);
					end else if (step_words.size() > 0) begin
						step_words[step_words.size()-1].final_word = 1'b1;
					end
					acc = '0;
					fill = '0;
					n_finishes++;
				end
				default: begin
				end
			endcase
			if (step_words.size() > 0)
				step_words[step_words.size()-1].end_of_run = 1'b1;
			foreach (step_words[i])
				expected_words.push_back(step_words[i]);
		endfunction

		// Called for every word popped from the block.
		function void check_word(out_item_t got);
			out_item_t want;
			n_words++;
			if (got.final_word)
				n_final++;
			if (expected_words.size() == 0) begin
				$error("unexpected word %h with nothing pending", got.packed_word);
				failures++;
				return;
			end
			want = expected_words.pop_front();
			if (got.packed_word !== want.packed_word) begin
				$error("packed_word mismatch: expected %h, got %h",
					want.packed_word, got.packed_word);
				failures++;
			end
			if (got.final_word !== want.final_word) begin
				$error("final_word mismatch: expected %b, got %b",
					want.final_word, got.final_word);
				failures++;
			end
			if (got.end_of_run !== want.end_of_run) begin
				$error("end_of_run mismatch: expected %b, got %b",
					want.end_of_run, got.end_of_run);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return expected_words.size();
		endfunction

		function int unsigned items_taken();
			return n_items;
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;

	packed_word_model_t model;
	int unsigned        burst_left;
	int unsigned        idle_cycles;
	int unsigned        full_stalls;

	huffman_code_bit_packer_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [63:0] rand_bits();
		return {$urandom, $urandom};
	endfunction

	function automatic in_item_t make_item(logic [CMD_W-1:0] c, int unsigned sym,
			int unsigned len, logic [63:0] bits);
		in_item_t it;
		it.cmd = c;
		it.symbol = SYM_W'(sym);
		it.code_length = CLEN_W'(len);
		it.code_bits = bits;
		return it;
	endfunction

	// Mostly short codes, with some long ones and lengths that saturate.
	function automatic int unsigned rand_code_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return 0;
		if (pick < 75)
			return $urandom_range(1, 12);
		if (pick < 90)
			return $urandom_range(13, 32);
		if (pick < 97)
			return $urandom_range(33, 64);
		return $urandom_range(65, 127);
	endfunction

	// Offer one word and hold it until accepted; bursts are broken up by random gaps.
	task automatic send_item(in_item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				push <= 1'b0;
				item <= make_item(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 511),
					$urandom_range(0, 127), rand_bits());
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		push <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (full);
		model.note_item(it);
		burst_left--;
	endtask

	task automatic load_code(int unsigned sym, int unsigned len, logic [63:0] bits);
		send_item(make_item(CMD_LOAD, sym, len, bits));
	endtask

	task automatic encode_byte(int unsigned sym);
		send_item(make_item(CMD_ENCODE, sym, $urandom_range(0, 127), rand_bits()));
	endtask

	task automatic finish_stream();
		send_item(make_item(CMD_FINISH, $urandom_range(0, 511), $urandom_range(0, 127),
			rand_bits()));
	endtask

	// Stop offering and wait until every owed word has been popped.
	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (model.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// Receiver: changes its stall pattern now and then, and holds off for a long
	// stretch twice so that both queues fill and full pushes back.
	initial begin : receiver
		pop_mode_t   mode;
		int unsigned mode_left, hold_left;
		mode = POP_ALWAYS;
		mode_left = 0;
		hold_left = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = pop_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(32, 256);
				end
				mode_left--;
				case (mode)
					POP_ALWAYS:  pop <= 1'b1;
					POP_MOSTLY:  pop <= ($urandom_range(0, 9) >= 3);
					POP_RARELY:  pop <= ($urandom_range(0, 9) >= 7);
					default:     pop <= ((mode_left % 8) < 5);
				endcase
			end
			@(posedge clk);
			if (pop && !empty) begin
				model.check_word(result);
				if (model.n_words == 40 || model.n_words == 150)
					hold_left = LONG_HOLD;
			end
		end
	end

	// Watchdog: ends the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (push && full)
			full_stalls++;
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no word moved for %0d cycles, %0d words still owed",
					idle_cycles, model.pending());
				$display("huffman_code_bit_packer_unit test failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		bit mid_drain_done;
		mid_drain_done = 1'b0;
		model = new();
		burst_left = 0;
		idle_cycles = 0;
		full_stalls = 0;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words: cleared table, saturation, ignored commands and word splits.
		encode_byte(5);
		finish_stream();
		load_code(0, 64, '1);
		load_code(255, 127, 64'hA5A5_5A5A_F00F_0FF0);
		load_code(EOS_SYMBOL, 3, 64'hFFFF_FFFF_FFFF_FFFD);
		load_code(1, 1, 64'h1);
		load_code(2, 61, 64'h5555_AAAA_3333_CCCC);
		load_code(300, 5, '1);
		load_code(511, 127, '1);
		send_item(make_item(CMD_UNUSED, 511, 127, '1));
		send_item(make_item(CMD_UNUSED, 0, 0, '0));
		// Byte 0 through an index above 255, then a full word from byte 255.
		encode_byte(256);
		encode_byte(511);
		encode_byte(1);
		encode_byte(0);
		finish_stream();
		// The end code lands exactly on the word boundary.
		encode_byte(2);
		finish_stream();
		// With an empty end code: an exact word, then a partial flush.
		load_code(EOS_SYMBOL, 0, '0);
		encode_byte(0);
		finish_stream();
		encode_byte(1);
		finish_stream();
		drain_results();

		// Random part: fill the whole table, then streams of encodes with noise.
		for (int s = 0; s <= EOS_SYMBOL; s++)
			load_code(s, rand_code_length(), rand_bits());
		while (model.items_taken() < TOTAL_ITEMS) begin
			if (!mid_drain_done && model.items_taken() >= TOTAL_ITEMS / 2) begin
				drain_results();
				mid_drain_done = 1'b1;
			end
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 8))
					load_code($urandom_range(0, EOS_SYMBOL), rand_code_length(), rand_bits());
			end
			repeat ($urandom_range(1, 40)) begin
				case ($urandom_range(0, 19))
					0: send_item(make_item(CMD_UNUSED, $urandom_range(0, 511),
						$urandom_range(0, 127), rand_bits()));
					1: load_code($urandom_range(NUM_SYMBOLS, 511), $urandom_range(0, 127),
						rand_bits());
					2: encode_byte($urandom_range(256, 511));
					default: encode_byte($urandom_range(0, 255));
				endcase
			end
			if ($urandom_range(0, 9) != 0)
				finish_stream();
		end
		drain_results();

		$display("Covered %0d table loads, %0d encodes and %0d stream ends; %0d words popped.",
			model.n_loads, model.n_encodes, model.n_finishes, model.n_words);
		$display("%0d of those words ended a stream; input held back by full for %0d cycles.",
			model.n_final, full_stalls);
		if (model.failures == 0 && model.pending() == 0) begin
			$display("huffman_code_bit_packer_unit test passed");
		end else begin
			$display("huffman_code_bit_packer_unit test failed");
		end
		$finish;
	end

endmodule
